[hw/rtl/rht_pkg.sv]
// Shared types and constants for the rainbow hue tint pipeline.
package rht_pkg;

  // Default hue period in columns; the top level hands it down as a parameter.
  localparam int unsigned HuePeriodDef = 64;

  // Field widths fixed by the pixel format.
  localparam int unsigned ColW    = 10;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned PhaseW  = 6;
  localparam int unsigned StrW    = 9;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 9;

  // Full-replacement strength; anything above saturates to it.
  localparam logic [StrW-1:0] StrFull = 9'd256;

  // floor(sum/3) for sum <= 765 as (sum * 683) >> 11.
  localparam logic [9:0] ThirdMul   = 10'd683;
  localparam int unsigned ThirdShift = 11;

  // Shift of the reciprocal used for the column modulo.
  localparam int unsigned RecipShift = 20;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_PHASE    = 1'd0,
    REG_BLEND_STRENGTH = 1'd1
  } cfg_reg_e;

  // Hue sectors of the color wheel, named by the two colors they span.
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // Sector and position inside it, as looked up from the hue phase.
  typedef struct packed {
    sector_e          sector;
    logic [ChanW-1:0] frac;
  } hue_code_t;

  typedef struct packed {
    logic [ColW-1:0]  column;
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
  } pix_out_t;

endpackage

[hw/rtl/rht_hue_lut.sv]
// Constant table from hue phase to color-wheel sector and fraction.
module rht_hue_lut #(
  parameter int unsigned HUE_PERIOD = rht_pkg::HuePeriodDef
) (
  input  logic [$clog2(HUE_PERIOD)-1:0] phase_i,
  output rht_pkg::hue_code_t            code_o
);
  import rht_pkg::*;

  localparam int unsigned PhW     = $clog2(HUE_PERIOD);
  localparam int unsigned Entries = 1 << PhW;

  hue_code_t tbl [Entries];

  // Codes past the period never get addressed; fill them with the last entry.
  for (genvar i = 0; i < Entries; i++) begin : g_tbl
    localparam int unsigned Pi   = (i < HUE_PERIOD) ? i : HUE_PERIOD - 1;
    localparam int unsigned HRaw = (Pi * 255) / HUE_PERIOD;
    localparam int unsigned Hue  = (HRaw > 254) ? 254 : HRaw;
    localparam int unsigned Sec  = (6 * Hue) / 255;
    localparam int unsigned Frac = (6 * Hue) % 255;
    assign tbl[i] = '{sector: sector_e'(3'(Sec)), frac: 8'(Frac)};
  end

  assign code_o = tbl[phase_i];

endmodule

[hw/rtl/rht_blend.sv]
// One color channel of the strength blend: orig + floor((rain - orig) * s / 256).
module rht_blend (
  input  logic [rht_pkg::ChanW-1:0] orig_i,
  input  logic [rht_pkg::ChanW-1:0] rain_i,
  input  logic [rht_pkg::StrW-1:0]  str_i,
  output logic [rht_pkg::ChanW-1:0] chan_o
);
  import rht_pkg::*;

  logic signed [ChanW:0]       diff;
  logic signed [ChanW+StrW:0]  prod;
  logic signed [ChanW+StrW:0]  delta;
  logic signed [ChanW+1:0]     sum;

  always_comb begin
    diff  = $signed({1'b0, rain_i}) - $signed({1'b0, orig_i});
    prod  = (ChanW+StrW+1)'(diff) * (ChanW+StrW+1)'($signed({1'b0, str_i}));
    delta = prod >>> 8;
    // Result stays within 0..255, so the low bits carry it exactly.
    sum    = $signed({2'b00, orig_i}) + delta[ChanW+1:0];
    chan_o = sum[ChanW-1:0];
  end

endmodule

[hw/rtl/rainbow_hue_tint_unit.sv]
// Top level of the rainbow hue tint pixel pipeline.
//
// Rainbow hue tint: takes one pixel per clock (column plus 8-bit red, green,
// blue) and returns one tinted pixel per clock while out_stall_i is low.
// Brightness v is the truncated mean of the three channels; the hue steps
// along the columns with a period of HUE_PERIOD columns and is shifted by
// frame_phase each frame. The resulting full-saturation rainbow color is
// blended with the input pixel by blend_strength in 1/256 steps (0 keeps the
// pixel, 256 and above replace it). The pipeline has six register stages.
// Each stage holds its own valid bit and moves up as soon as the stage after
// it is empty or moving, so bubbles close up and a stall on the output holds
// every beat in place without loss. Write registers only while the pipeline
// is empty.
module rainbow_hue_tint_unit #(
  parameter int unsigned HUE_PERIOD = rht_pkg::HuePeriodDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Pixel input beat
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rht_pkg::pix_in_t            in_data_i,
  // Tinted pixel output beat
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rht_pkg::pix_out_t           out_data_o,
  // Register writes
  input  logic                        cfg_we_i,
  input  logic [rht_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rht_pkg::CfgW-1:0]    cfg_wdata_i
);
  import rht_pkg::*;

  localparam int unsigned NumStages = 6;
  localparam int unsigned PhW       = $clog2(HUE_PERIOD);
  localparam int unsigned SumW      = ChanW + 2;
  localparam int unsigned XW        = 11;
  localparam int unsigned MW        = RecipShift;
  localparam int unsigned ProdXW    = XW + MW;
  // floor(x / HUE_PERIOD) is at most one low with this reciprocal for x < 2^11.
  localparam logic [MW-1:0] RecipM  = MW'((1 << RecipShift) / HUE_PERIOD);
  localparam logic [XW-1:0] HueDiv  = XW'(HUE_PERIOD);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PhaseW-1:0] phase_q;
  logic [StrW-1:0]   str_q;
  logic [StrW-1:0]   str_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      str_q   <= StrFull;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_PHASE:    phase_q <= cfg_wdata_i[PhaseW-1:0];
        REG_BLEND_STRENGTH: str_q   <= cfg_wdata_i[StrW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate strength to full replacement.
  assign str_sat = (str_q > StrFull) ? StrFull : str_q;

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage advances when it is empty or the next one
  // advances. The ready chain runs from the output back to the input.
  // ---------------------------------------------------------------------------
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: channel sum and shifted column.
  // ---------------------------------------------------------------------------
  logic [3*ChanW-1:0] rgb1_q;
  logic [SumW-1:0]    sum1_q;
  logic [XW-1:0]      x1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      rgb1_q <= {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};
      sum1_q <= SumW'(in_data_i.in_red) + SumW'(in_data_i.in_green)
              + SumW'(in_data_i.in_blue);
      x1_q   <= XW'(phase_q) + XW'(in_data_i.column);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: value by reciprocal of three, quotient estimate of the period.
  // ---------------------------------------------------------------------------
  logic [3*ChanW-1:0] rgb2_q;
  logic [ChanW-1:0]   v2_q;
  logic [XW-1:0]      x2_q;
  logic [XW-1:0]      q2_q;
  logic [2*SumW-1:0]  v_prod;
  logic [ProdXW-1:0]  x_prod;

  always_comb begin
    v_prod = (2*SumW)'(sum1_q) * (2*SumW)'(ThirdMul);
    x_prod = ProdXW'(x1_q) * ProdXW'(RecipM);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      rgb2_q <= rgb1_q;
      v2_q   <= v_prod[ThirdShift +: ChanW];
      x2_q   <= x1_q;
      q2_q   <= x_prod[RecipShift +: XW];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: remainder, with one correcting subtract.
  // ---------------------------------------------------------------------------
  logic [3*ChanW-1:0] rgb3_q;
  logic [ChanW-1:0]   v3_q;
  logic [PhW-1:0]     p3_q;
  logic [XW-1:0]      rem_raw;
  logic [XW-1:0]      rem_fix;

  always_comb begin
    // True remainder is below twice the period, so 11-bit wraparound is exact.
    rem_raw = x2_q - XW'(q2_q * HueDiv);
    rem_fix = (rem_raw >= HueDiv) ? (rem_raw - HueDiv) : rem_raw;
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      rgb3_q <= rgb2_q;
      v3_q   <= v2_q;
      p3_q   <= rem_fix[PhW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: sector lookup and ramp product v * f (or v * (255 - f)).
  // ---------------------------------------------------------------------------
  hue_code_t            code;
  logic [ChanW-1:0]     ramp_n;
  logic [3*ChanW-1:0]   rgb4_q;
  logic [ChanW-1:0]     v4_q;
  sector_e              sec4_q;
  logic [2*ChanW-1:0]   tp4_q;

  rht_hue_lut #(
    .HUE_PERIOD(HUE_PERIOD)
  ) u_hue_lut (
    .phase_i(p3_q),
    .code_o (code)
  );

  // Odd sectors ramp down, even ones ramp up.
  assign ramp_n = code.sector[0] ? (8'd255 - code.frac) : code.frac;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      rgb4_q <= rgb3_q;
      v4_q   <= v3_q;
      sec4_q <= code.sector;
      tp4_q  <= (2*ChanW)'(v3_q) * (2*ChanW)'(ramp_n);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: ramp / 255 and sector mux into the rainbow color.
  // ---------------------------------------------------------------------------
  logic [2*ChanW:0]   t_sum;
  logic [ChanW-1:0]   ramp_t;
  logic [ChanW-1:0]   rr, rg, rb;
  logic [3*ChanW-1:0] rgb5_q;
  logic [3*ChanW-1:0] rain5_q;

  always_comb begin
    // floor(y / 255) = (y + 1 + (y >> 8)) >> 8 for y below 65535.
    t_sum  = (2*ChanW+1)'(tp4_q) + (2*ChanW+1)'(1)
           + (2*ChanW+1)'(tp4_q[2*ChanW-1:ChanW]);
    ramp_t = t_sum[ChanW +: ChanW];
    rr = '0;
    rg = '0;
    rb = '0;
    case (sec4_q)
      SEC_RED_YEL: begin
        rr = v4_q;
        rg = ramp_t;
      end
      SEC_YEL_GRN: begin
        rr = ramp_t;
        rg = v4_q;
      end
      SEC_GRN_CYN: begin
        rg = v4_q;
        rb = ramp_t;
      end
      SEC_CYN_BLU: begin
        rg = ramp_t;
        rb = v4_q;
      end
      SEC_BLU_MAG: begin
        rr = ramp_t;
        rb = v4_q;
      end
      default: begin
        rr = v4_q;
        rb = ramp_t;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      rgb5_q  <= rgb4_q;
      rain5_q <= {rr, rg, rb};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: blend each channel with the original and hold the output beat.
  // ---------------------------------------------------------------------------
  logic [ChanW-1:0] bl_r, bl_g, bl_b;
  pix_out_t         out_q;

  rht_blend u_blend_r (
    .orig_i(rgb5_q[2*ChanW +: ChanW]),
    .rain_i(rain5_q[2*ChanW +: ChanW]),
    .str_i (str_sat),
    .chan_o(bl_r)
  );

  rht_blend u_blend_g (
    .orig_i(rgb5_q[ChanW +: ChanW]),
    .rain_i(rain5_q[ChanW +: ChanW]),
    .str_i (str_sat),
    .chan_o(bl_g)
  );

  rht_blend u_blend_b (
    .orig_i(rgb5_q[0 +: ChanW]),
    .rain_i(rain5_q[0 +: ChanW]),
    .str_i (str_sat),
    .chan_o(bl_b)
  );

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      out_q <= '{out_red: bl_r, out_green: bl_g, out_blue: bl_b};
    end
  end

  assign out_data_o = out_q;

endmodule
